/* src/dcmsc_pkg.sv */
// shared types, constants and helper functions for the dc motor controller
// no dependencies
package dcmsc_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int RES_WIDTH = 20;
   localparam int TOL_WIDTH = 9;
   localparam int WIN_WIDTH = 16;
   localparam int ELAPSED_WIDTH = 16;
   localparam int POT_WIDTH = 10;
   localparam int DUTY_WIDTH = 8;
   localparam int RPM_WIDTH = 32;
   localparam int SCALE_WIDTH = 30;
   localparam int DEN_WIDTH = RES_WIDTH + ELAPSED_WIDTH;
   localparam int DIV_STEPS = RPM_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
   localparam int ADDR_WIDTH = 4;
   localparam int DATA_WIDTH = 32;

   localparam logic [SCALE_WIDTH-1:0] RPM_SCALE = 30'd600000000;
   localparam logic [RES_WIDTH-1:0] RES_RESET = 20'd37422;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 9'd2;
   localparam logic [WIN_WIDTH-1:0] WIN_RESET = 16'd1000;
   localparam logic [DUTY_WIDTH-1:0] DUTY_FULL = 8'd255;

   typedef enum logic [1:0] {
      REG_RESOLUTION = 2'd0,
      REG_TOLERANCE  = 2'd1,
      REG_WINDOW     = 2'd2,
      REG_NONE       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_ENC    = 2'd1,
      ACT_BUTTON = 2'd2,
      ACT_POT    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_PREP,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic prep;
      logic check;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic sat;
   } status_type;

   // x / 1023 for x below 1023 * 512
   function automatic logic [8:0] div1023(input logic [18:0] x);
      logic [8:0] q0;
      logic [10:0] r;
      q0 = x[18:10];
      r = {1'b0, x[9:0]} + {2'b00, q0};
      div1023 = (r >= 11'd1023) ? q0 + 9'd1 : q0;
   endfunction

endpackage

/* src/dc_motor_speed_position_controller_top.sv */
// top level of the dc motor speed and position controller: csr bank and wiring
// depends on dcmsc_pkg, dcmsc_ctrl and dcmsc_datapath
// a transaction is accepted only when idle, after the previous result has been loaded
// a closed speed window without saturation runs the 32-step serial rpm divider first
// reset: synchronous, clears mode, counters and pot sample; registers return to defaults
module dc_motor_speed_position_controller_top
   import dcmsc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic                  req_enc_b,
   input  logic [POT_WIDTH-1:0]  req_pot_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DUTY_WIDTH-1:0] rsp_pwm_duty,
   output logic                  rsp_direction,
   output logic                  rsp_speed_mode,
   output logic                  rsp_rpm_valid,
   output logic [RPM_WIDTH-1:0]  rsp_rpm_centi,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [DATA_WIDTH-1:0] csr_pwdata,
   output logic [DATA_WIDTH-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [RES_WIDTH-1:0] res_ff;
   logic [TOL_WIDTH-1:0] tol_ff;
   logic [WIN_WIDTH-1:0] win_ff;
   logic wr;
   reg_index_type idx;
   cmd_type cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign idx = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
         tol_ff <= TOL_RESET;
         win_ff <= WIN_RESET;
      end else if (wr) begin
         unique case (idx)
            REG_RESOLUTION: res_ff <= csr_pwdata[RES_WIDTH-1:0];
            REG_TOLERANCE:  tol_ff <= csr_pwdata[TOL_WIDTH-1:0];
            REG_WINDOW:     win_ff <= csr_pwdata[WIN_WIDTH-1:0];
            default:        res_ff <= res_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RESOLUTION: csr_prdata = DATA_WIDTH'(res_ff);
         REG_TOLERANCE:  csr_prdata = DATA_WIDTH'(tol_ff);
         REG_WINDOW:     csr_prdata = DATA_WIDTH'(win_ff);
         default:        csr_prdata = '0;
      endcase
   end

   dcmsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dcmsc_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_enc_b      (req_enc_b),
      .req_pot_value  (req_pot_value),
      .cfg_resolution (res_ff),
      .cfg_tolerance  (tol_ff),
      .cfg_window     (win_ff),
      .rsp_pwm_duty   (rsp_pwm_duty),
      .rsp_direction  (rsp_direction),
      .rsp_speed_mode (rsp_speed_mode),
      .rsp_rpm_valid  (rsp_rpm_valid),
      .rsp_rpm_centi  (rsp_rpm_centi)
   );

endmodule

/* src/dcmsc_ctrl.sv */
// sequencer for the dc motor controller: event handshake, steps, divider count
// depends on dcmsc_pkg
module dcmsc_ctrl
   import dcmsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            cnt_in = DIV_CNT_WIDTH'(DIV_STEPS - 1);
            state_in = (status.hit && !status.sat) ? S_DIV : S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_APPLY)
      else $error("accepted transaction did not start processing");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && cnt_ff == '0 |=> state_ff == S_DONE)
      else $error("divider did not finish after last step");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("result overwrote a pending transaction");

endmodule

/* src/dcmsc_datapath.sv */
// datapath of the dc motor controller: event state, products, compare, rpm divider
// depends on dcmsc_pkg, driven by dcmsc_ctrl commands
module dcmsc_datapath
   import dcmsc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [1:0]            req_action,
   input  logic                  req_enc_b,
   input  logic [POT_WIDTH-1:0]  req_pot_value,
   input  logic [RES_WIDTH-1:0]  cfg_resolution,
   input  logic [TOL_WIDTH-1:0]  cfg_tolerance,
   input  logic [WIN_WIDTH-1:0]  cfg_window,
   output logic [DUTY_WIDTH-1:0] rsp_pwm_duty,
   output logic                  rsp_direction,
   output logic                  rsp_speed_mode,
   output logic                  rsp_rpm_valid,
   output logic [RPM_WIDTH-1:0]  rsp_rpm_centi
);

   localparam int NUM_WIDTH = COUNT_WIDTH + SCALE_WIDTH;
   localparam int POSV_WIDTH = COUNT_WIDTH + 17;
   localparam int WIDE_WIDTH = DEN_WIDTH + RPM_WIDTH;

   logic [1:0] act_ff;
   logic encb_ff;
   logic [POT_WIDTH-1:0] potin_ff;

   logic mode_ff, mode_in;
   logic signed [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] pulse_ff, pulse_in;
   logic [ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [POT_WIDTH-1:0] pot_ff, pot_in;

   logic hit_ff, sat_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic signed [POSV_WIDTH-1:0] posv_ff;
   logic [DUTY_WIDTH-1:0] duty_ff;
   logic dir_ff;
   logic [DEN_WIDTH-1:0] rem_ff;
   logic [RPM_WIDTH-1:0] quo_ff;

   logic [DUTY_WIDTH-1:0] out_duty_ff;
   logic out_dir_ff, out_mode_ff, out_valid_ff;
   logic [RPM_WIDTH-1:0] out_rpm_ff;

   logic [RES_WIDTH-1:0] res;
   logic [WIN_WIDTH-1:0] win;
   logic [8:0] ang, spd_duty;
   logic signed [10:0] ang_s, tol_s, diff_s, sum_s;
   logic signed [20:0] res_s;
   logic signed [31:0] lo_in, hi_in;
   logic signed [POSV_WIDTH-1:0] posv_in;
   logic sat;
   logic [DEN_WIDTH:0] trial;
   logic ge;

   localparam logic signed [COUNT_WIDTH-1:0] POS_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] POS_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   assign res = (cfg_resolution == '0) ? RES_WIDTH'(1) : cfg_resolution;
   assign win = (cfg_window == '0) ? WIN_WIDTH'(1) : cfg_window;

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      pulse_in = pulse_ff;
      elapsed_in = elapsed_ff;
      pot_in = pot_ff;
      if (cmd.apply) begin
         unique case (action_type'(act_ff))
            ACT_TICK: begin
               if (elapsed_ff != '1) elapsed_in = elapsed_ff + 1'b1;
            end
            ACT_ENC: begin
               if (mode_ff) begin
                  if (pulse_ff != '1) pulse_in = pulse_ff + 1'b1;
               end else if (encb_ff) begin
                  if (pos_ff != POS_MAX) pos_in = pos_ff + COUNT_WIDTH'(1);
               end else begin
                  if (pos_ff != POS_MIN) pos_in = pos_ff - COUNT_WIDTH'(1);
               end
            end
            ACT_BUTTON: begin
               mode_in = !mode_ff;
               pos_in = '0;
            end
            ACT_POT: pot_in = potin_ff;
            default: pot_in = pot_ff;
         endcase
      end else if (cmd.prep && mode_ff && (elapsed_ff >= win)) begin
         pulse_in = '0;
         elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         pos_ff <= '0;
         pulse_ff <= '0;
         elapsed_ff <= '0;
         pot_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         pulse_ff <= pulse_in;
         elapsed_ff <= elapsed_in;
         pot_ff <= pot_in;
      end
   end

   // position band products, speed duty, rpm saturation and divider trial compares
   always_comb begin
      ang = div1023(19'(pot_ff) * 19'd360);
      spd_duty = div1023(19'(pot_ff) * 19'd255);
      ang_s = $signed({2'b00, ang});
      tol_s = $signed({2'b00, cfg_tolerance});
      diff_s = ang_s - tol_s;
      sum_s = ang_s + tol_s;
      res_s = $signed({1'b0, res});
      lo_in = diff_s * res_s;
      hi_in = sum_s * res_s;
      posv_in = pos_ff * $signed(17'sd36000);
      sat = {{(WIDE_WIDTH-NUM_WIDTH){1'b0}}, num_ff} >= {den_ff, {RPM_WIDTH{1'b0}}};
      trial = {rem_ff, quo_ff[RPM_WIDTH-1]};
      ge = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         encb_ff <= req_enc_b;
         potin_ff <= req_pot_value;
      end
      if (cmd.prep) begin
         hit_ff <= mode_ff && (elapsed_ff >= win);
         num_ff <= NUM_WIDTH'(pulse_ff) * NUM_WIDTH'(RPM_SCALE);
         den_ff <= DEN_WIDTH'(res) * DEN_WIDTH'(elapsed_ff);
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         posv_ff <= posv_in;
      end
      if (cmd.check) begin
         sat_ff <= sat;
         rem_ff <= {{(DEN_WIDTH-(NUM_WIDTH-RPM_WIDTH)){1'b0}}, num_ff[NUM_WIDTH-1:RPM_WIDTH]};
         quo_ff <= num_ff[RPM_WIDTH-1:0];
         if (mode_ff) begin
            duty_ff <= spd_duty[DUTY_WIDTH-1:0];
            dir_ff <= 1'b0;
         end else if (lo_ff > posv_ff) begin
            duty_ff <= DUTY_FULL;
            dir_ff <= 1'b1;
         end else if (hi_ff < posv_ff) begin
            duty_ff <= DUTY_FULL;
            dir_ff <= 1'b0;
         end else begin
            duty_ff <= '0;
            dir_ff <= 1'b1;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? DEN_WIDTH'(trial - {1'b0, den_ff}) : trial[DEN_WIDTH-1:0];
         quo_ff <= {quo_ff[RPM_WIDTH-2:0], ge};
      end
      if (cmd.out_load) begin
         out_duty_ff <= duty_ff;
         out_dir_ff <= dir_ff;
         out_mode_ff <= mode_ff;
         out_valid_ff <= hit_ff;
         out_rpm_ff <= !hit_ff ? '0 : (sat_ff ? '1 : quo_ff);
      end
   end

   assign status.hit = hit_ff;
   assign status.sat = sat;

   assign rsp_pwm_duty = out_duty_ff;
   assign rsp_direction = out_dir_ff;
   assign rsp_speed_mode = out_mode_ff;
   assign rsp_rpm_valid = out_valid_ff;
   assign rsp_rpm_centi = out_rpm_ff;

endmodule
